/* src/amlss_pkg.sv */
// Package with the types, codes and helpers of the AML sleep state scanner.
`default_nettype none

package amlss_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned SCALE_SHIFT = 10;
    localparam int unsigned KEEP_W = WORD_W - SCALE_SHIFT;

    localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CHAR_S = 8'h53;
    localparam logic [BYTE_W-1:0] CHAR_FIVE = 8'h35;

    localparam logic [BYTE_W-1:0] OP_PACKAGE = 8'h12;
    localparam logic [BYTE_W-1:0] OP_BYTE_PREFIX = 8'h0A;
    localparam logic [BYTE_W-1:0] OP_WORD_PREFIX = 8'h0B;
    localparam logic [BYTE_W-1:0] OP_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] OP_ONE = 8'h01;
    localparam logic [BYTE_W-1:0] OP_ONES = 8'hFF;

    typedef enum logic [3:0] {
        PH_MATCH0 = 4'd0,
        PH_MATCH1 = 4'd1,
        PH_MATCH2 = 4'd2,
        PH_MATCH3 = 4'd3,
        PH_NAME_DONE = 4'd4,
        PH_LEAD = 4'd5,
        PH_EXTRA = 4'd6,
        PH_COUNT = 4'd7,
        PH_A_OP = 4'd8,
        PH_A_BYTE = 4'd9,
        PH_A_LO = 4'd10,
        PH_A_HI = 4'd11,
        PH_B_OP = 4'd12,
        PH_B_BYTE = 4'd13,
        PH_B_LO = 4'd14,
        PH_B_HI = 4'd15
    } phase_t;

    // Shifting left by the scale and keeping a word leaves only the low bits.
    function automatic logic [WORD_W-1:0] scale_low(input logic [KEEP_W-1:0] v);
        return {v, {SCALE_SHIFT{1'b0}}};
    endfunction

    // Value of an element given by a single opcode with no data bytes.
    function automatic logic [WORD_W-1:0] const_value(input logic [BYTE_W-1:0] op);
        logic [WORD_W-1:0] v;
        v = '0;
        case (op)
            OP_ONE: v = scale_low(KEEP_W'(1));
            OP_ONES: v = scale_low({KEEP_W{1'b1}});
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/amlss_byte_if.sv */
// Channel interface that carries the bytes of an AML table body.
`default_nettype none

interface amlss_byte_if
    import amlss_pkg::*;
    ();
    logic valid;
    logic ready;
    logic [BYTE_W-1:0] aml_byte;
    logic last_of_table;

    modport source (output valid, output aml_byte, output last_of_table, input ready);
    modport sink (input valid, input aml_byte, input last_of_table, output ready);
endinterface

`default_nettype wire

/* src/amlss_result_if.sv */
// Channel interface that carries the sleep type result of one table.
`default_nettype none

interface amlss_result_if
    import amlss_pkg::*;
    ();
    logic valid;
    logic ready;
    logic found;
    logic [WORD_W-1:0] sleep_type_a_word;
    logic [WORD_W-1:0] sleep_type_b_word;

    modport source (output valid, output found, output sleep_type_a_word,
                    output sleep_type_b_word, input ready);
    modport sink (input valid, input found, input sleep_type_a_word,
                  input sleep_type_b_word, output ready);
endinterface

`default_nettype wire

/* src/aml_sleep_state_scanner_unit.sv */
// Top level of the AML sleep state scanner: name search and package decode.
//
// Channel  Direction  Payload                                      Per transfer
// aml      in         aml_byte, last_of_table                      one table byte
// result   out        found, sleep_type_a_word, sleep_type_b_word  one table result
//
// A byte can be accepted in every cycle while the input is not stalled.
// A result appears in the output register on the cycle after the byte that causes it.
// The input stalls only while a result sits in the output register and is not taken.
// Reset clears the scan phase, the skip count and the output valid flag at once, but not the result data.
`default_nettype none

module aml_sleep_state_scanner_unit
    import amlss_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    amlss_byte_if.sink aml,
    amlss_result_if.source result
);

    phase_t phase_reg;
    phase_t phase_next;
    logic [1:0] skip_reg;
    logic [1:0] skip_next;
    logic [WORD_W-1:0] first_reg;
    logic [WORD_W-1:0] first_next;
    logic [KEEP_W-1:0] pend_reg;
    logic [KEEP_W-1:0] pend_next;
    logic sent_reg;

    logic out_valid_reg;
    logic found_reg;
    logic [WORD_W-1:0] a_word_reg;
    logic [WORD_W-1:0] b_word_reg;

    logic [BYTE_W-1:0] b;
    logic accept;
    logic elem_done;
    logic in_b;
    logic [WORD_W-1:0] elem_val;
    logic result_done;
    logic emit;

    assign b = aml.aml_byte;
    assign aml.ready = !out_valid_reg || result.ready;
    assign accept = aml.valid && aml.ready;

    // Output decode: completion and value of the element in the current byte.
    always_comb
    begin
        elem_done = 1'b0;
        elem_val = '0;
        unique case (phase_reg) inside
            PH_A_OP, PH_B_OP:
            begin
                elem_done = (b != OP_BYTE_PREFIX) && (b != OP_WORD_PREFIX);
                elem_val = const_value(b);
            end
            PH_A_BYTE, PH_B_BYTE:
            begin
                elem_done = 1'b1;
                elem_val = scale_low(b[KEEP_W-1:0]);
            end
            PH_A_HI, PH_B_HI:
            begin
                elem_done = 1'b1;
                elem_val = scale_low(pend_reg);
            end
            default:
            begin
                elem_done = 1'b0;
                elem_val = '0;
            end
        endcase
        in_b = (phase_reg == PH_B_OP) || (phase_reg == PH_B_BYTE)
            || (phase_reg == PH_B_LO) || (phase_reg == PH_B_HI);
        result_done = elem_done && in_b;
        emit = accept && !sent_reg && (result_done || aml.last_of_table);
    end

    // Next state of the scan.
    always_comb
    begin
        phase_next = phase_reg;
        skip_next = skip_reg;
        first_next = first_reg;
        pend_next = pend_reg;
        unique case (phase_reg)
            PH_MATCH0, PH_MATCH3:
            begin
                if (b == CHAR_UNDERSCORE)
                    phase_next = (phase_reg == PH_MATCH0) ? PH_MATCH1 : PH_NAME_DONE;
                else
                    phase_next = PH_MATCH0;
            end
            PH_MATCH1:
            begin
                if (b == CHAR_S)
                    phase_next = PH_MATCH2;
                else if (b == CHAR_UNDERSCORE)
                    phase_next = PH_MATCH1;
                else
                    phase_next = PH_MATCH0;
            end
            PH_MATCH2:
            begin
                if (b == CHAR_FIVE)
                    phase_next = PH_MATCH3;
                else if (b == CHAR_UNDERSCORE)
                    phase_next = PH_MATCH1;
                else
                    phase_next = PH_MATCH0;
            end
            PH_NAME_DONE:
            begin
                if (b == OP_PACKAGE)
                    phase_next = PH_LEAD;
                else if (b == CHAR_S)
                    phase_next = PH_MATCH2;
                else if (b == CHAR_UNDERSCORE)
                    phase_next = PH_MATCH1;
                else
                    phase_next = PH_MATCH0;
            end
            PH_LEAD:
            begin
                skip_next = b[BYTE_W-1:BYTE_W-2];
                phase_next = (b[BYTE_W-1:BYTE_W-2] != 2'd0) ? PH_EXTRA : PH_COUNT;
            end
            PH_EXTRA:
            begin
                skip_next = skip_reg - 2'd1;
                if (skip_reg == 2'd1)
                    phase_next = PH_COUNT;
            end
            PH_COUNT:
            begin
                phase_next = PH_A_OP;
            end
            PH_A_OP, PH_B_OP:
            begin
                if (b == OP_BYTE_PREFIX)
                    phase_next = (phase_reg == PH_A_OP) ? PH_A_BYTE : PH_B_BYTE;
                else if (b == OP_WORD_PREFIX)
                    phase_next = (phase_reg == PH_A_OP) ? PH_A_LO : PH_B_LO;
                else
                    phase_next = (phase_reg == PH_A_OP) ? PH_B_OP : PH_MATCH0;
            end
            PH_A_BYTE, PH_A_HI:
            begin
                phase_next = PH_B_OP;
            end
            PH_A_LO:
            begin
                pend_next = b[KEEP_W-1:0];
                phase_next = PH_A_HI;
            end
            PH_B_LO:
            begin
                pend_next = b[KEEP_W-1:0];
                phase_next = PH_B_HI;
            end
            PH_B_BYTE, PH_B_HI:
            begin
                phase_next = PH_MATCH0;
            end
        endcase
        if (elem_done && !in_b)
            first_next = elem_val;
        if (result_done)
            skip_next = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MATCH0;
            skip_reg <= 2'd0;
            first_reg <= '0;
            pend_reg <= '0;
            sent_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (aml.last_of_table)
            begin
                phase_reg <= PH_MATCH0;
                skip_reg <= 2'd0;
                first_reg <= '0;
                pend_reg <= '0;
                sent_reg <= 1'b0;
            end
            else if (!sent_reg)
            begin
                phase_reg <= phase_next;
                skip_reg <= skip_next;
                first_reg <= first_next;
                pend_reg <= pend_next;
                sent_reg <= result_done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg <= result_done;
            a_word_reg <= result_done ? first_reg : '0;
            b_word_reg <= result_done ? elem_val : '0;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.found = found_reg;
    assign result.sleep_type_a_word = a_word_reg;
    assign result.sleep_type_b_word = b_word_reg;

endmodule

`default_nettype wire

/* test/aml_sleep_state_scanner_unit_check.sv */
// Checker that predicts the sleep type result of each AML table and compares it with the block.
`timescale 1ns / 100ps

module aml_sleep_state_scanner_unit_check
    import amlss_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    amlss_byte_if aml,
    amlss_result_if result,
    output int mismatches,
    output int awaited
);

    typedef struct packed {
        logic found;
        logic [WORD_W-1:0] a_word;
        logic [WORD_W-1:0] b_word;
    } sleep_result_t;

    sleep_result_t sleep_results_q[$];
    sleep_result_t oldest;

    phase_t phase;
    logic [1:0] skip_left;
    logic [WORD_W-1:0] a_word;
    logic [BYTE_W-1:0] low_byte;
    logic reported;

    task automatic clear_scan();
        phase = PH_MATCH0;
        skip_left = '0;
        a_word = '0;
        low_byte = '0;
        reported = 1'b0;
    endtask

    // Advances the scan by one table byte and queues the result it causes, if any.
    task automatic predict_sleep_type(input logic [BYTE_W-1:0] b, input logic last);
        logic done;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] b_word;
        done = 1'b0;
        value = '0;
        if (!reported)
        begin
            case (phase)
                PH_MATCH0:
                    phase = (b == CHAR_UNDERSCORE) ? PH_MATCH1 : PH_MATCH0;
                PH_MATCH1:
                    phase = (b == CHAR_S) ? PH_MATCH2 :
                            (b == CHAR_UNDERSCORE) ? PH_MATCH1 : PH_MATCH0;
                PH_MATCH2:
                    phase = (b == CHAR_FIVE) ? PH_MATCH3 :
                            (b == CHAR_UNDERSCORE) ? PH_MATCH1 : PH_MATCH0;
                PH_MATCH3:
                    phase = (b == CHAR_UNDERSCORE) ? PH_NAME_DONE : PH_MATCH0;
                PH_NAME_DONE:
                    phase = (b == OP_PACKAGE) ? PH_LEAD :
                            (b == CHAR_S) ? PH_MATCH2 :
                            (b == CHAR_UNDERSCORE) ? PH_MATCH1 : PH_MATCH0;
                PH_LEAD:
                begin
                    skip_left = b[7:6];
                    phase = (b[7:6] != 2'd0) ? PH_EXTRA : PH_COUNT;
                end
                PH_EXTRA:
                begin
                    skip_left = skip_left - 2'd1;
                    if (skip_left == 2'd0)
                    begin
                        phase = PH_COUNT;
                    end
                end
                PH_COUNT:
                    phase = PH_A_OP;
                PH_A_OP, PH_B_OP:
                begin
                    case (b)
                        OP_BYTE_PREFIX: phase = phase_t'(phase + 4'd1);
                        OP_WORD_PREFIX: phase = phase_t'(phase + 4'd2);
                        OP_ONE:
                        begin
                            value = 16'd1;
                            done = 1'b1;
                        end
                        OP_ONES:
                        begin
                            value = 16'hFFFF;
                            done = 1'b1;
                        end
                        default:
                        begin
                            value = '0;
                            done = 1'b1;
                        end
                    endcase
                end
                PH_A_BYTE, PH_B_BYTE:
                begin
                    value = {8'h00, b};
                    done = 1'b1;
                end
                PH_A_LO, PH_B_LO:
                begin
                    low_byte = b;
                    phase = phase_t'(phase + 4'd1);
                end
                default:
                begin
                    value = {b, low_byte};
                    done = 1'b1;
                end
            endcase

            if (done)
            begin
                if (phase < PH_B_OP)
                begin
                    a_word = value << SCALE_SHIFT;
                    phase = PH_B_OP;
                end
                else
                begin
                    b_word = value << SCALE_SHIFT;
                    sleep_results_q.push_back('{found: 1'b1, a_word: a_word, b_word: b_word});
                    reported = 1'b1;
                    phase = PH_MATCH0;
                    skip_left = '0;
                end
            end

            if (last && !reported)
            begin
                sleep_results_q.push_back('{found: 1'b0, a_word: '0, b_word: '0});
            end
        end
        if (last)
        begin
            clear_scan();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            sleep_results_q.delete();
            mismatches = 0;
            awaited = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (sleep_results_q.size() == 0)
                begin
                    $error("result transfer with no result expected");
                    mismatches++;
                end
                else
                begin
                    oldest = sleep_results_q.pop_front();
                    if (result.found !== oldest.found)
                    begin
                        $error("found: expected %0d, got %0d", oldest.found, result.found);
                        mismatches++;
                    end
                    if (result.sleep_type_a_word !== oldest.a_word)
                    begin
                        $error("sleep_type_a_word: expected 0x%04h, got 0x%04h",
                               oldest.a_word, result.sleep_type_a_word);
                        mismatches++;
                    end
                    if (result.sleep_type_b_word !== oldest.b_word)
                    begin
                        $error("sleep_type_b_word: expected 0x%04h, got 0x%04h",
                               oldest.b_word, result.sleep_type_b_word);
                        mismatches++;
                    end
                end
            end
            if (aml.valid && aml.ready)
            begin
                predict_sleep_type(aml.aml_byte, aml.last_of_table);
            end
            awaited = sleep_results_q.size();
        end
    end

endmodule

/* test/aml_sleep_state_scanner_unit_test.sv */
// Testbench top of the AML sleep state scanner: table stimulus, idling and the verdict.
`timescale 1ns / 100ps

module aml_sleep_state_scanner_unit_test;
    import amlss_pkg::*;

    localparam int unsigned ITEM_TARGET = 1350;
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    int mismatches;
    int awaited;
    bit hold_off;
    bit steady;
    bit pause_done;
    bit hold_done;
    int unsigned idle_cycles;
    int unsigned bytes_sent;
    logic [BYTE_W-1:0] table_q[$];

    amlss_byte_if aml_ch ();
    amlss_result_if result_ch ();

    aml_sleep_state_scanner_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .aml(aml_ch),
        .result(result_ch)
    );

    aml_sleep_state_scanner_unit_check i_check (
        .clk(clk),
        .rst_n(rst_n),
        .aml(aml_ch),
        .result(result_ch),
        .mismatches(mismatches),
        .awaited(awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last_flag);
        int unsigned r;
        int unsigned gap;
        aml_ch.valid = 1'b1;
        aml_ch.aml_byte = b;
        aml_ch.last_of_table = last_flag;
        @(posedge clk);
        while (!aml_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!steady)
        begin
            if (r >= 95)
            begin
                gap = $urandom_range(10, 60);
            end
            else if (r >= 65)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap != 0)
        begin
            aml_ch.valid = 1'b0;
            aml_ch.aml_byte = 8'($urandom);
            aml_ch.last_of_table = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_table();
        for (int i = 0; i < table_q.size(); i++)
        begin
            send_byte(table_q[i], i == table_q.size() - 1);
        end
    endtask

    function automatic logic [BYTE_W-1:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return CHAR_UNDERSCORE;
            1: return CHAR_S;
            2: return CHAR_FIVE;
            3: return OP_PACKAGE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_element();
        logic [BYTE_W-1:0] op;
        case ($urandom_range(0, 5))
            0:
            begin
                table_q.push_back(OP_BYTE_PREFIX);
                table_q.push_back(8'($urandom));
            end
            1:
            begin
                table_q.push_back(OP_WORD_PREFIX);
                table_q.push_back(8'($urandom));
                table_q.push_back(8'($urandom));
            end
            2: table_q.push_back(OP_ZERO);
            3: table_q.push_back(OP_ONE);
            4: table_q.push_back(OP_ONES);
            default:
            begin
                op = 8'($urandom);
                while (op inside {OP_BYTE_PREFIX, OP_WORD_PREFIX, OP_ZERO, OP_ONE, OP_ONES})
                begin
                    op = 8'($urandom);
                end
                table_q.push_back(op);
            end
        endcase
    endtask

    // Mostly well-formed sleep packages with random content; the rest is noise or cut short.
    task automatic build_table();
        logic [BYTE_W-1:0] lead;
        int unsigned keep;
        table_q.delete();
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 12)) table_q.push_back(noise_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 5)) table_q.push_back(noise_byte());
            if ($urandom_range(0, 2) == 0)
            begin
                table_q.push_back(CHAR_UNDERSCORE);
                table_q.push_back(CHAR_S);
                table_q.push_back(CHAR_FIVE);
                if ($urandom_range(0, 1) == 0)
                begin
                    table_q.push_back(CHAR_UNDERSCORE);
                end
                table_q.push_back(noise_byte());
            end
            table_q.push_back(CHAR_UNDERSCORE);
            table_q.push_back(CHAR_S);
            table_q.push_back(CHAR_FIVE);
            table_q.push_back(CHAR_UNDERSCORE);
            table_q.push_back(OP_PACKAGE);
            lead = 8'($urandom);
            table_q.push_back(lead);
            repeat (lead[7:6]) table_q.push_back(8'($urandom));
            table_q.push_back(8'($urandom));
            add_element();
            add_element();
            repeat ($urandom_range(0, 4)) table_q.push_back(noise_byte());
            if ($urandom_range(0, 6) == 0)
            begin
                keep = $urandom_range(1, table_q.size() - 1);
                while (table_q.size() > keep)
                begin
                    void'(table_q.pop_back());
                end
            end
        end
    endtask

    initial
    begin
        int unsigned r;
        int unsigned span;
        logic level;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off)
            begin
                result_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (steady)
                begin
                    level = 1'b1;
                    span = 1;
                end
                else if (r < 55)
                begin
                    level = 1'b1;
                    span = $urandom_range(1, 16);
                end
                else if (r < 93)
                begin
                    level = 1'b0;
                    span = $urandom_range(1, 3);
                end
                else
                begin
                    level = 1'b0;
                    span = $urandom_range(15, 60);
                end
                result_ch.ready = level;
                repeat (span) @(negedge clk);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((aml_ch.valid && aml_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        aml_ch.valid = 1'b0;
        aml_ch.aml_byte = '0;
        aml_ch.last_of_table = 1'b0;
        hold_off = 1'b0;
        steady = 1'b0;
        pause_done = 1'b0;
        hold_done = 1'b0;
        bytes_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Full match that completes on the last byte, with byte and word elements.
        table_q = '{CHAR_UNDERSCORE, CHAR_S, CHAR_FIVE, CHAR_UNDERSCORE, OP_PACKAGE,
                    8'h00, 8'h00, OP_BYTE_PREFIX, 8'hFF, OP_WORD_PREFIX, 8'h34, 8'hFF};
        send_table();
        // Overlapping name, then the table ends inside the package length.
        table_q = '{CHAR_UNDERSCORE, CHAR_S, CHAR_FIVE, CHAR_UNDERSCORE, CHAR_S, CHAR_FIVE,
                    CHAR_UNDERSCORE, OP_PACKAGE, 8'hC0};
        send_table();
        // Two extra length bytes, one and ones elements, then a byte that is ignored.
        table_q = '{CHAR_UNDERSCORE, CHAR_S, CHAR_FIVE, CHAR_UNDERSCORE, OP_PACKAGE,
                    8'h80, 8'hAA, 8'hBB, 8'h07, OP_ONE, OP_ONES, OP_ZERO};
        send_table();

        while (bytes_sent < ITEM_TARGET)
        begin
            if (bytes_sent >= 400 && !pause_done)
            begin
                aml_ch.valid = 1'b0;
                while (awaited != 0)
                begin
                    @(negedge clk);
                end
                pause_done = 1'b1;
            end
            if (bytes_sent >= 600 && !hold_done)
            begin
                hold_off = 1'b1;
                repeat (30)
                begin
                    table_q = '{8'($urandom)};
                    send_table();
                end
                hold_done = 1'b1;
            end
            steady = (bytes_sent >= 900 && bytes_sent < 1100);
            build_table();
            send_table();
        end
        steady = 1'b0;
        aml_ch.valid = 1'b0;

        while (awaited != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
